// ===== design/rfq_pkg.sv =====
// ============================================================================
// rfq_pkg: shared types, constants and the control program for the ring FIFO
// Holds the transaction payloads, the status and operation codes and the
// microcode table that the sequencer steps through.
// ============================================================================
`default_nettype none

package rfq_pkg;

    // Geometry
    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int VALUE_W   = 16;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int AHEAD_W   = 5;
    localparam int OCC_W     = 5;
    localparam int STEP_W    = 4;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [STEP_W-1:0] step_t;

    // Operation codes; the last one is unused and leaves the ring alone
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Transaction payloads
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  popped;
        logic [AHEAD_W-1:0]  ahead;
        logic [OCC_W-1:0]    occupancy;
    } res_t;

    // Datapath actions, one per control word
    typedef enum logic [3:0] {
        A_NONE,
        A_LATCH,
        A_PUSH,
        A_POP_RD,
        A_POP,
        A_Q_START,
        A_Q_CMP,
        A_EMIT
    } action_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_ACC,
        C_OP_PUSH,
        C_OP_POP,
        C_OP_QUERY,
        C_EMPTY,
        C_STOP,
        C_OUT_FREE
    } cond_t;

    // Condition flags from the datapath
    typedef struct packed {
        logic in_acc;
        logic op_push;
        logic op_pop;
        logic op_query;
        logic empty;
        logic stop;
        logic out_free;
    } flags_t;

    typedef struct packed {
        action_t act;
        cond_t   cond;
        step_t   jmp;
        step_t   nxt;
    } ctrl_word_t;

    // Program addresses
    localparam step_t S_WAIT     = 4'd0;
    localparam step_t S_DISP     = 4'd1;
    localparam step_t S_PUSH     = 4'd2;
    localparam step_t S_DISP2    = 4'd3;
    localparam step_t S_POP_RD   = 4'd4;
    localparam step_t S_POP      = 4'd5;
    localparam step_t S_DISP3    = 4'd6;
    localparam step_t S_Q_START  = 4'd7;
    localparam step_t S_Q_CMP    = 4'd8;
    localparam step_t S_EMIT     = 4'd9;

    // Control store: jump to jmp when the condition holds, else go to nxt
    function automatic ctrl_word_t rfq_program(step_t step);
        ctrl_word_t w;
        unique case (step)
            S_WAIT:    w = '{act: A_LATCH,   cond: C_IN_ACC,   jmp: S_DISP,    nxt: S_WAIT};
            S_DISP:    w = '{act: A_NONE,    cond: C_OP_PUSH,  jmp: S_PUSH,    nxt: S_DISP2};
            S_PUSH:    w = '{act: A_PUSH,    cond: C_ALWAYS,   jmp: S_EMIT,    nxt: S_EMIT};
            S_DISP2:   w = '{act: A_NONE,    cond: C_OP_POP,   jmp: S_POP_RD,  nxt: S_DISP3};
            S_POP_RD:  w = '{act: A_POP_RD,  cond: C_EMPTY,    jmp: S_EMIT,    nxt: S_POP};
            S_POP:     w = '{act: A_POP,     cond: C_ALWAYS,   jmp: S_EMIT,    nxt: S_EMIT};
            S_DISP3:   w = '{act: A_NONE,    cond: C_OP_QUERY, jmp: S_Q_START, nxt: S_EMIT};
            S_Q_START: w = '{act: A_Q_START, cond: C_EMPTY,    jmp: S_EMIT,    nxt: S_Q_CMP};
            S_Q_CMP:   w = '{act: A_Q_CMP,   cond: C_STOP,     jmp: S_EMIT,    nxt: S_Q_CMP};
            S_EMIT:    w = '{act: A_EMIT,    cond: C_OUT_FREE, jmp: S_WAIT,    nxt: S_EMIT};
            default:   w = '{act: A_NONE,    cond: C_ALWAYS,   jmp: S_WAIT,    nxt: S_WAIT};
        endcase
        return w;
    endfunction

    // Advance a ring index with wrap
    function automatic idx_t rfq_next(idx_t i);
        idx_t r;
        if (i == IDX_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/rfq_ram.sv =====
// ============================================================================
// rfq_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ============================================================================
`default_nettype none

module rfq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/rfq_seq.sv =====
// ============================================================================
// rfq_seq: microcode sequencer for the ring FIFO
// Holds the step counter, fetches the control word and resolves jumps.
// ============================================================================
`default_nettype none

module rfq_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rfq_pkg::flags_t     flags,
    output rfq_pkg::ctrl_word_t      ctrl
);

    import rfq_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  taken;

    // Fetch the current control word
    assign ctrl = rfq_program(step_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:   taken = 1'b1;
            C_IN_ACC:   taken = flags.in_acc;
            C_OP_PUSH:  taken = flags.op_push;
            C_OP_POP:   taken = flags.op_pop;
            C_OP_QUERY: taken = flags.op_query;
            C_EMPTY:    taken = flags.empty;
            C_STOP:     taken = flags.stop;
            C_OUT_FREE: taken = flags.out_free;
            default:    taken = 1'b1;
        endcase
        step_next = taken ? ctrl.jmp : ctrl.nxt;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ring_fifo_with_position_query_core.sv =====
// ============================================================================
// ring_fifo_with_position_query_core: ring FIFO with position query
// Circular FIFO of ticket values with push, pop and a search that reports
// how many entries stand ahead of the first match. Microcoded control.
// ============================================================================
//
//   Channel  Dir  Handshake              Payload
//   cmd      in   cmd_valid / cmd_stall  rfq_pkg::cmd_t (op, value)
//   res      out  res_valid / res_stall  rfq_pkg::res_t (status, popped,
//                                        ahead, occupancy)
//
// One command at a time, from acceptance to the next acceptance: push runs
// dispatch, write, emit; pop runs dispatch, head read, advance (skipped on an
// empty ring), emit; the unused op runs dispatch, emit; a query compares n
// entries (0 on an empty ring, else 1 to occupancy), one per cycle through
// the single RAM read port and comparator. A stalled result waits at emit.
// Reset clears head, tail, count, the step counter and res_valid; stored
// tickets are not cleared and no clearing pass runs.
// ============================================================================
`default_nettype none

module ring_fifo_with_position_query_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire rfq_pkg::cmd_t   cmd,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output rfq_pkg::res_t        res
);

    import rfq_pkg::*;

    ctrl_word_t ctrl;
    flags_t     flags;

    // Control state
    idx_t head_reg, head_next;
    idx_t tail_reg, tail_next;
    cnt_t count_reg, count_next;
    logic res_valid_reg, res_valid_next;

    // Payload state
    logic [OP_W-1:0]     op_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  popped_reg, popped_next;
    cnt_t                ahead_reg, ahead_next;
    idx_t                ptr_reg, ptr_next;
    cnt_t                k_reg, k_next;
    res_t                res_reg, res_next;

    // Memory ports
    logic                ram_we;
    idx_t                ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    logic accept;
    logic empty;
    logic full;
    logic out_free;
    logic match;
    logic last;

    rfq_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    rfq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (value_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and status flags
    assign cmd_stall = (ctrl.act != A_LATCH);
    assign accept    = cmd_valid && !cmd_stall;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_free  = !res_valid_reg || !res_stall;
    assign match     = (ram_rdata == value_reg);
    assign last      = (CNT_W'(k_reg + 1'b1) == count_reg);

    assign flags = '{
        in_acc:   accept,
        op_push:  (op_reg == OP_PUSH),
        op_pop:   (op_reg == OP_POP),
        op_query: (op_reg == OP_QUERY),
        empty:    empty,
        stop:     match || last,
        out_free: out_free
    };

    // Read at the head to start a pop or a scan, else at the next scan slot
    assign ram_raddr = (ctrl.act == A_POP_RD || ctrl.act == A_Q_START)
                       ? head_reg : rfq_next(ptr_reg);
    assign ram_we    = (ctrl.act == A_PUSH) && !full;

    // Datapath actions
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        ahead_next     = ahead_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        unique case (ctrl.act)
            A_LATCH:
            begin
                status_next = ST_OK;
                popped_next = '0;
                ahead_next  = '0;
            end
            A_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    tail_next  = rfq_next(tail_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            A_POP_RD:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
            end
            A_POP:
            begin
                popped_next = ram_rdata;
                head_next   = rfq_next(head_reg);
                count_next  = count_reg - 1'b1;
            end
            A_Q_START:
            begin
                ptr_next = head_reg;
                k_next   = '0;
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
            end
            A_Q_CMP:
            begin
                if (match)
                begin
                    status_next = ST_OK;
                    ahead_next  = k_reg;
                end
                else if (last)
                begin
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    k_next   = k_reg + 1'b1;
                    ptr_next = rfq_next(ptr_reg);
                end
            end
            A_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next     = 1'b1;
                    res_next.status    = status_reg;
                    res_next.popped    = popped_reg;
                    res_next.ahead     = AHEAD_W'(ahead_reg);
                    res_next.occupancy = OCC_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold payload state; capture the command on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= cmd.op;
            value_reg <= cmd.value;
        end
        status_reg <= status_next;
        popped_reg <= popped_next;
        ahead_reg  <= ahead_next;
        ptr_reg    <= ptr_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Occupancy never exceeds the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

    // A refused push is reported only with a full ring
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_FULL |-> res.occupancy == OCC_W'(DEPTH))
    else $error("full status with free slots");

    // An empty report always carries zero occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_EMPTY |-> res.occupancy == '0)
    else $error("empty status with live entries");

    // Leaving the emit step always presents a result
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.act == A_EMIT && out_free |=> res_valid)
    else $error("result dropped at emit");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ============================================================================
// testbench: regression for ring_fifo_with_position_query_core
// Drives push, pop, position query and unused commands through the cmd
// channel and checks every result on the res channel against a behavioural
// ticket FIFO kept in step with each accepted command. Directed cases cover
// empty, full, duplicates and misses; random traffic swings the occupancy
// between empty and full under bursty input and a stalling output.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import rfq_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 50;

    logic  clk;
    logic  rst_n     = 1'b0;
    logic  cmd_valid = 1'b0;
    logic  cmd_stall;
    cmd_t  cmd       = '0;
    logic  res_valid;
    logic  res_stall = 1'b0;
    res_t  res;

    // Behavioural copy of the ticket ring
    logic [VALUE_W-1:0] mdl_slots [DEPTH];
    int                 mdl_head;
    int                 mdl_tail;
    int                 mdl_fill;

    // Results still owed by the block, oldest first
    res_t awaited_res_q [$];

    int   mismatch_count = 0;
    int   cycle_count    = 0;

    // Sender burst state
    int   burst_left = 0;
    bit   gaps_on    = 1'b1;

    // Receiver stall state
    int   hold_token = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;
    int   stall_mode = 0;
    int   seg_left   = 0;

    res_t want;

    ring_fifo_with_position_query_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ring_fifo_with_position_query_core regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        end
        mismatch_count++;
    endtask

    function automatic void fifo_model_reset();
        mdl_head = 0;
        mdl_tail = 0;
        mdl_fill = 0;
        foreach (mdl_slots[i])
        begin
            mdl_slots[i] = '0;
        end
    endfunction

    // Apply one command to the ring copy and return the result it owes
    function automatic res_t fifo_model_step(input cmd_t c);
        res_t r;
        int   idx;
        bit   hit;
        r = '0;
        r.status = ST_OK;
        case (c.op)
            OP_PUSH:
            begin
                if (mdl_fill >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    mdl_slots[mdl_tail] = c.value;
                    mdl_tail = (mdl_tail + 1) % DEPTH;
                    mdl_fill++;
                end
            end
            OP_POP:
            begin
                if (mdl_fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.popped = mdl_slots[mdl_head];
                    mdl_head = (mdl_head + 1) % DEPTH;
                    mdl_fill--;
                end
            end
            OP_QUERY:
            begin
                if (mdl_fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.status = ST_NOTFOUND;
                    idx = mdl_head;
                    hit = 1'b0;
                    for (int k = 0; k < mdl_fill; k++)
                    begin
                        if (!hit && mdl_slots[idx] == c.value)
                        begin
                            hit = 1'b1;
                            r.status = ST_OK;
                            r.ahead = AHEAD_W'(k);
                        end
                        idx = (idx + 1) % DEPTH;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(mdl_fill);
        return r;
    endfunction

    // Offer one transaction, wait for acceptance, then predict its result
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        cmd_t c;
        int   gap;
        c.op = op;
        c.value = value;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 3);
                if (gap > 0)
                begin
                    cmd_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        awaited_res_q.push_back(fifo_model_step(c));
    endtask

    // Hold off input until every owed result is back, then let the block settle
    task automatic drain_results();
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (awaited_res_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: own stall pattern, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                seg_left   = $urandom_range(10, 80);
            end
            seg_left--;
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                default: res_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Compare each accepted result with the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (awaited_res_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %p", res));
            end
            else
            begin
                want = awaited_res_q.pop_front();
                if (res.status !== want.status)
                begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              res.status, want.status));
                end
                if (res.popped !== want.popped)
                begin
                    report_mismatch($sformatf("popped %h, want %h",
                                              res.popped, want.popped));
                end
                if (res.ahead !== want.ahead)
                begin
                    report_mismatch($sformatf("ahead %0d, want %0d",
                                              res.ahead, want.ahead));
                end
                if (res.occupancy !== want.occupancy)
                begin
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              res.occupancy, want.occupancy));
                end
            end
        end
    end

    // Pop, query and unused command on an empty ring
    task automatic test_empty_ring();
        send_cmd(OP_POP, 16'hFFFF);
        send_cmd(OP_QUERY, 16'hFFFF);
        send_cmd(OP_NOP, 16'h0000);
        drain_results();
    endtask

    // Fill to the brim, refuse a push, search for duplicates, a late entry and a miss
    task automatic test_full_ring();
        send_cmd(OP_PUSH, 16'h0000);
        send_cmd(OP_PUSH, 16'hFFFF);
        for (int i = 2; i < DEPTH - 1; i++)
        begin
            send_cmd(OP_PUSH, VALUE_W'(i * 16'h1111));
        end
        send_cmd(OP_PUSH, 16'hFFFF);
        send_cmd(OP_PUSH, 16'h7777);
        send_cmd(OP_QUERY, 16'hFFFF);
        send_cmd(OP_QUERY, 16'hEEEE);
        send_cmd(OP_QUERY, 16'h1357);
        send_cmd(OP_NOP, 16'hFFFF);
        drain_results();
    endtask

    // Stop the receiver for a long stretch while commands keep coming
    task automatic test_output_holdoff();
        gaps_on = 1'b0;
        hold_token++;
        for (int i = 0; i < 24; i++)
        begin
            send_cmd(($urandom_range(0, 2) == 0) ? OP_QUERY : OP_PUSH,
                     VALUE_W'($urandom_range(0, 7)));
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    // Random traffic with phases that push the ring toward full, then empty
    task automatic test_random_traffic(input int n_items, input bit with_gaps);
        int                 sent;
        int                 r;
        bit                 filling;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        gaps_on = with_gaps;
        sent    = 0;
        filling = 1'b1;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                filling = ~filling;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                op = OP_NOP;
            end
            else if (r < 28)
            begin
                op = OP_QUERY;
            end
            else if ($urandom_range(0, 99) < (filling ? 75 : 25))
            begin
                op = OP_PUSH;
            end
            else
            begin
                op = OP_POP;
            end
            if (op == OP_QUERY && mdl_fill > 0 && $urandom_range(0, 3) != 0)
            begin
                value = mdl_slots[(mdl_head + $urandom_range(0, mdl_fill - 1)) % DEPTH];
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                value = VALUE_W'($urandom_range(0, 7));
            end
            else
            begin
                value = VALUE_W'($urandom_range(0, 65535));
            end
            send_cmd(op, value);
            if (op != OP_NOP)
            begin
                sent++;
            end
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        fifo_model_reset();
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_full_ring();
        test_random_traffic(450, 1'b1);
        test_output_holdoff();
        test_random_traffic(250, 1'b0);
        test_random_traffic(300, 1'b1);

        if (mismatch_count == 0)
        begin
            $display("ring_fifo_with_position_query_core regression: pass");
        end
        else
        begin
            $display("ring_fifo_with_position_query_core regression: fail");
        end
        $finish;
    end

endmodule
